>>> rtl/core/round_robin_thread_queue_defines.svh
// Assertion macros for the round-robin thread queue checker.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef ROUND_ROBIN_THREAD_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_THREAD_QUEUE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define RRTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define RRTQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/rrtq_pkg.sv
// Shared constants, codes and types for the round-robin thread queue.
// Used by the cell, the cell row, the top level and the checker.
package rrtq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FUNC_W      = 3;
  localparam int STS_W       = 2;
  localparam int ACT_W       = 3;

  localparam logic [FUNC_W-1:0] OP_INIT        = 3'd0;
  localparam logic [FUNC_W-1:0] OP_ACTIVATE    = 3'd1;
  localparam logic [FUNC_W-1:0] OP_DEACTIVATE  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_SCHEDULE    = 3'd3;
  localparam logic [FUNC_W-1:0] OP_MARK_EXITED = 3'd4;

  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL      = 2'd1;
  localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd2;

  // Per-cycle action broadcast to every cell.
  localparam logic [ACT_W-1:0] ACT_HOLD   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MARK   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_DROP   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd6;

  typedef struct packed {
    logic [ACT_W-1:0]   act;
    logic [ID_BITS-1:0] id;
    logic [CNT_W-1:0]   count;
  } cell_ctl_t;

  typedef struct packed {
    logic               found;
    logic               live;
    logic [ID_BITS-1:0] head_id;
    logic               head_exited;
  } chain_sts_t;

endpackage

>>> rtl/core/rrtq_cell.sv
// One queue slot: thread identifier plus exited mark, with neighbor links.
// Depends on rrtq_pkg.
module rrtq_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrtq_pkg::cell_ctl_t         ctl,
  input  logic [rrtq_pkg::IDX_W-1:0]  idx,
  input  logic [rrtq_pkg::ID_BITS-1:0] right_id,
  input  logic                        right_exited,
  input  logic                        found_in,
  input  logic                        live_in,
  output logic [rrtq_pkg::ID_BITS-1:0] id,
  output logic                        exited,
  output logic                        found_out,
  output logic                        live_out
);
  import rrtq_pkg::*;

  logic [ID_BITS-1:0] id_r, id_nxt;
  logic               exited_r, exited_nxt;
  logic [CNT_W-1:0]   my_pos;
  logic               valid;
  logic               match;

  assign my_pos    = CNT_W'(idx);
  assign valid     = my_pos < ctl.count;
  assign match     = valid && (id_r == ctl.id);
  // Inclusive prefix: this slot or one nearer the head holds the first match.
  assign found_out = found_in | match;
  assign live_out  = live_in | (valid & ~exited_r);

  always_comb begin
    id_nxt     = id_r;
    exited_nxt = exited_r;
    unique case (ctl.act)
      ACT_CLEAR: begin
        exited_nxt = 1'b0;
      end
      ACT_APPEND: begin
        if (my_pos == ctl.count) begin
          id_nxt     = ctl.id;
          exited_nxt = 1'b0;
        end
      end
      ACT_REMOVE: begin
        if (found_out) begin
          id_nxt     = right_id;
          exited_nxt = right_exited;
        end
      end
      ACT_MARK: begin
        if (match) begin
          exited_nxt = 1'b1;
        end
      end
      ACT_DROP: begin
        id_nxt     = right_id;
        exited_nxt = right_exited;
      end
      ACT_POP: begin
        // Advance toward the head; the last occupied slot takes the outgoing thread.
        if (my_pos + CNT_W'(1) == ctl.count) begin
          id_nxt     = ctl.id;
          exited_nxt = 1'b0;
        end else begin
          id_nxt     = right_id;
          exited_nxt = right_exited;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    if (!rst_n) begin
      exited_r <= 1'b0;
    end else begin
      exited_r <= exited_nxt;
    end
  end

  assign id     = id_r;
  assign exited = exited_r;

endmodule

>>> rtl/core/rrtq_chain.sv
// Row of queue cells, head at position zero, with the match and live chains.
// Depends on rrtq_pkg and rrtq_cell.
module rrtq_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  rrtq_pkg::cell_ctl_t ctl,
  output rrtq_pkg::chain_sts_t sts
);
  import rrtq_pkg::*;

  logic [ID_BITS-1:0] id_w     [QUEUE_DEPTH];
  logic               exited_w [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] found_w;
  logic [QUEUE_DEPTH:0] live_w;

  assign found_w[0] = 1'b0;
  assign live_w[0]  = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_BITS-1:0] r_id;
    logic               r_exited;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_id     = '0;
      assign r_exited = 1'b0;
    end else begin : g_mid
      assign r_id     = id_w[i+1];
      assign r_exited = exited_w[i+1];
    end
    rrtq_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .idx          (IDX_W'(i)),
      .right_id     (r_id),
      .right_exited (r_exited),
      .found_in     (found_w[i]),
      .live_in      (live_w[i]),
      .id           (id_w[i]),
      .exited       (exited_w[i]),
      .found_out    (found_w[i+1]),
      .live_out     (live_w[i+1])
    );
  end

  assign sts.found       = found_w[QUEUE_DEPTH];
  assign sts.live        = live_w[QUEUE_DEPTH];
  assign sts.head_id     = id_w[0];
  assign sts.head_exited = exited_w[0];

endmodule

>>> rtl/core/round_robin_thread_queue.sv
// Top level of the round-robin ready-queue scheduler.
// Depends on rrtq_pkg and rrtq_chain.
//
// A command transaction is taken when start is high and busy is low. The
// block then executes it in the run state and presents the result on the
// out_ ports for a single cycle, marked by out_valid; busy is already low in
// that cycle, so a new command may be taken at its end. The receiver
// cannot stall: out_valid drops after that cycle. Schedule stays in the run
// state while it drops exited entries from the head of the queue, one at a
// time. A schedule that drops anything always leaves at least one live
// entry behind, so it drops at most 15 entries. The row of queue cells
// shifts one slot toward the head per cycle. The match and live chains
// ripple through the sixteen cells within the execute cycle.
module round_robin_thread_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rrtq_pkg::FUNC_W-1:0]  in_func,
  input  logic [rrtq_pkg::ID_BITS-1:0] in_thread_id,
  output logic                         out_valid,
  output logic [rrtq_pkg::ID_BITS-1:0] out_current_id,
  output logic                         out_switched,
  output logic [rrtq_pkg::CNT_W-1:0]   out_queue_count,
  output logic [rrtq_pkg::STS_W-1:0]   out_status
);
  import rrtq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic               state_r, state_nxt;
  logic [FUNC_W-1:0]  func_r;
  logic [ID_BITS-1:0] cmd_id_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [ID_BITS-1:0] cur_r, cur_nxt;

  logic               out_valid_r;
  logic [ID_BITS-1:0] out_cur_r;
  logic               out_sw_r;
  logic [CNT_W-1:0]   out_cnt_r;
  logic [STS_W-1:0]   out_sts_r;

  cell_ctl_t  ctl;
  chain_sts_t csts;
  logic               done;
  logic               sw;
  logic [STS_W-1:0]   sts;
  logic               accept;

  assign accept = start && (state_r == S_IDLE);

  rrtq_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (csts)
  );

  // Decode the held command into one cell action per execute cycle.
  always_comb begin
    ctl.act   = ACT_HOLD;
    ctl.id    = cmd_id_r;
    ctl.count = count_r;
    count_nxt = count_r;
    cur_nxt   = cur_r;
    sts       = STS_OK;
    sw        = 1'b0;
    done      = 1'b0;
    if (state_r == S_RUN) begin
      done = 1'b1;
      unique case (func_r)
        OP_INIT: begin
          // Empty the queue and clear every exited mark.
          ctl.act   = ACT_CLEAR;
          cur_nxt   = cmd_id_r;
          count_nxt = '0;
        end
        OP_ACTIVATE: begin
          if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            sts = STS_FULL;
          end else begin
            ctl.act   = ACT_APPEND;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        OP_DEACTIVATE: begin
          if (csts.found) begin
            ctl.act   = ACT_REMOVE;
            count_nxt = count_r - CNT_W'(1);
          end else begin
            sts = STS_NOT_FOUND;
          end
        end
        OP_MARK_EXITED: begin
          ctl.act = ACT_MARK;
        end
        OP_SCHEDULE: begin
          if (csts.live) begin
            if (csts.head_exited) begin
              // Drop one exited head and stay in the execute state.
              ctl.act   = ACT_DROP;
              count_nxt = count_r - CNT_W'(1);
              done      = 1'b0;
            end else begin
              // Pop the head as the new thread; the old one joins the tail.
              ctl.act = ACT_POP;
              ctl.id  = cur_r;
              cur_nxt = csts.head_id;
              sw      = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = S_RUN;
    end else if (done) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      cmd_id_r <= in_thread_id;
    end
    if (done) begin
      out_cur_r <= cur_nxt;
      out_sw_r  <= sw;
      out_cnt_r <= count_nxt;
      out_sts_r <= sts;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= done;
    end
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_current_id  = out_cur_r;
  assign out_switched    = out_sw_r;
  assign out_queue_count = out_cnt_r;
  assign out_status      = out_sts_r;

endmodule

>>> rtl/core/rrtq_checker.sv
// Port-level checker for the round-robin thread queue, bound to the top.
// Depends on rrtq_pkg and round_robin_thread_queue_defines.svh.
`include "round_robin_thread_queue_defines.svh"

module rrtq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         out_switched,
  input logic [rrtq_pkg::CNT_W-1:0]   out_queue_count,
  input logic [rrtq_pkg::STS_W-1:0]   out_status
);
  import rrtq_pkg::*;

  `RRTQ_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> (!busy && !out_valid), "not idle after reset")
  `RRTQ_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted command did not raise busy")
  `RRTQ_ASSERT(a_single_strobe, out_valid |=> !out_valid, "result strobe held over two cycles")
  `RRTQ_ASSERT(a_strobe_idle, out_valid |-> !busy, "result shown while busy")
  `RRTQ_ASSERT(a_switch_sane, (out_valid && out_switched) |-> ((out_status == STS_OK) && (out_queue_count != '0) && (out_queue_count <= CNT_W'(QUEUE_DEPTH))), "bad switch result")

endmodule

bind round_robin_thread_queue rrtq_checker u_rrtq_checker (.*);
